// ----- rtl/sampled_trace_ring_thread_topn_core_macros.svh -----
// Assertion helpers for the trace ring core.
`ifndef SAMPLED_TRACE_RING_THREAD_TOPN_CORE_MACROS_SVH
`define SAMPLED_TRACE_RING_THREAD_TOPN_CORE_MACROS_SVH

// Same-cycle implication.
`define STRTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STRTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/strtt_pkg.sv -----
package strtt_pkg;

  localparam int unsigned IdW    = 16;
  localparam int unsigned SizeW  = 32;
  localparam int unsigned TotW   = 44;
  localparam int unsigned CntW   = 13;
  localparam int unsigned EntW   = IdW + SizeW;

  localparam logic [1:0] RegEnable     = 2'd0;
  localparam logic [1:0] RegSampleRate = 2'd1;
  localparam logic [1:0] RegMaxGroups  = 2'd2;

  localparam logic OpLog    = 1'b0;
  localparam logic OpReport = 1'b1;

  typedef struct packed {
    logic             v;
    logic [IdW-1:0]   id;
    logic [SizeW-1:0] sz;
  } ent_t;

  typedef struct packed {
    logic            v;
    logic [IdW-1:0]  id;
    logic [TotW-1:0] tot;
    logic [CntW-1:0] cnt;
  } grp_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } ctl_t;

endpackage

// ----- rtl/strtt_cell.sv -----
module strtt_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  strtt_pkg::ctl_t ctl_i,
  input  logic            allow_i,
  input  strtt_pkg::ent_t ent_i,
  output strtt_pkg::ent_t ent_o,
  input  strtt_pkg::grp_t shin_i,
  output strtt_pkg::grp_t grp_o
);

  strtt_pkg::grp_t grp_q;
  strtt_pkg::ent_t ent_q;
  logic [strtt_pkg::TotW:0] sum;

  assign sum   = {1'b0, grp_q.tot} + {{(strtt_pkg::TotW + 1 - strtt_pkg::SizeW){1'b0}}, ent_i.sz};
  assign grp_o = grp_q;
  assign ent_o = ent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q <= '0;
      ent_q <= '0;
    end else if (ctl_i.clear) begin
      grp_q.v <= 1'b0;
      ent_q.v <= 1'b0;
    end else if (ctl_i.shift) begin
      grp_q   <= shin_i;
      ent_q.v <= 1'b0;
    end else begin
      ent_q.v <= 1'b0;
      if (ent_i.v) begin
        if (grp_q.v && grp_q.id == ent_i.id) begin
          grp_q.tot <= sum[strtt_pkg::TotW] ? '1 : sum[strtt_pkg::TotW-1:0];
          if (grp_q.cnt != '1) begin
            grp_q.cnt <= grp_q.cnt + 1'b1;
          end
        end else if (!grp_q.v && allow_i) begin
          grp_q.v   <= 1'b1;
          grp_q.id  <= ent_i.id;
          grp_q.tot <= {{(strtt_pkg::TotW - strtt_pkg::SizeW){1'b0}}, ent_i.sz};
          grp_q.cnt <= {{(strtt_pkg::CntW - 1){1'b0}}, 1'b1};
        end else begin
          ent_q <= ent_i;
        end
      end
    end
  end

endmodule

// ----- rtl/sampled_trace_ring_thread_topn_core.sv -----
// Log transfer: a new one every cycle while idle.
// Report: ring reads of the filled entries from oldest, a drain of the cell chain, then per group a
// rotation of the cell chain plus an emit that waits for the output register; an empty report
// emits a single result flagged empty and last.
// No input is taken until the last result of a report is in the output register.
// Reset (async, active low) clears pointer, fill, phase and cells and sets config to its defaults; ring is not cleared.
`include "sampled_trace_ring_thread_topn_core_macros.svh"

module sampled_trace_ring_thread_topn_core #(
  parameter int unsigned RING_DEPTH = 4096,
  parameter int unsigned GROUPS     = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // thread, size
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // group_thread, total_bytes, event_count, zero pad
  output logic        m_axis_tuser,   // empty_res
  output logic        m_axis_tlast
);

  localparam int unsigned PW  = $clog2(RING_DEPTH);
  localparam int unsigned FW  = $clog2(RING_DEPTH + 1);
  localparam int unsigned LW  = $clog2(GROUPS + 1);
  localparam int unsigned DW  = $clog2(GROUPS + 2);

  typedef enum logic [2:0] {
    S_IDLE, S_EMPTY, S_WALK, S_DRAIN, S_SORT, S_EMIT
  } state_e;

  state_e        state_q;
  logic          enable_q;
  logic [15:0]   rate_q;
  logic [4:0]    maxg_q;
  logic [PW-1:0] wp_q;
  logic [FW-1:0] fill_q;
  logic [15:0]   phase_q;
  logic [PW-1:0] rd_addr_q;
  logic [FW-1:0] rd_cnt_q;
  logic          rd_v_q;
  logic [strtt_pkg::EntW-1:0] rd_data_q;
  logic [strtt_pkg::EntW-1:0] ring_q [RING_DEPTH];
  logic [DW-1:0] drain_q;
  logic [LW-1:0] step_q;
  strtt_pkg::grp_t hold_q;
  logic          hold_v_q;
  logic          rem_q;
  logic          out_valid_q;
  logic [79:0]   out_data_q;
  logic          out_empty_q;
  logic          out_last_q;

  logic          in_acc;
  logic          keep;
  logic [16:0]   phase_nx;
  logic [15:0]   rate_eff;
  logic [LW-1:0] limit;
  logic [PW:0]   start_w;
  logic [PW-1:0] start;
  logic          out_free;
  logic          issue;

  strtt_pkg::ctl_t ctl;
  strtt_pkg::ent_t feed;
  strtt_pkg::grp_t tail;
  strtt_pkg::ent_t ent_c [GROUPS];
  strtt_pkg::grp_t grp_c [GROUPS];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign keep          = in_acc && (s_axis_tuser == strtt_pkg::OpLog) && enable_q && phase_q == '0;
  assign rate_eff      = (rate_q == '0) ? 16'd1 : rate_q;
  assign phase_nx      = {1'b0, phase_q} + 17'd1;
  assign limit         = ({27'd0, maxg_q} > GROUPS) ? LW'(GROUPS) : LW'(maxg_q);
  assign start_w       = ({1'b0, wp_q} + (PW + 1)'(RING_DEPTH) - (PW + 1)'(fill_q));
  assign start         = ((PW + 1)'(fill_q) > {1'b0, wp_q}) ? start_w[PW-1:0]
                                                            : PW'({1'b0, wp_q} - (PW + 1)'(fill_q));
  assign out_free      = !out_valid_q || m_axis_tready;
  assign issue         = (state_q == S_WALK) && (rd_cnt_q != fill_q);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_empty_q;
  assign m_axis_tlast  = out_last_q;

  assign ctl.clear = in_acc && (s_axis_tuser == strtt_pkg::OpReport);
  assign ctl.shift = (state_q == S_SORT);

  assign feed.v  = rd_v_q;
  assign feed.id = rd_data_q[strtt_pkg::IdW-1:0];
  assign feed.sz = rd_data_q[strtt_pkg::EntW-1:strtt_pkg::IdW];

  always_comb begin
    tail   = grp_c[0];
    tail.v = 1'b0;
    if (grp_c[0].v && hold_v_q) begin
      tail = (grp_c[0].tot > hold_q.tot) ? hold_q : grp_c[0];
    end
  end

  for (genvar k = 0; k < GROUPS; k++) begin : g_cell
    strtt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .allow_i (LW'(k) < limit),
      .ent_i   ((k == 0) ? feed : ent_c[(k == 0) ? 0 : k - 1]),
      .ent_o   (ent_c[k]),
      .shin_i  ((k == GROUPS - 1) ? tail : grp_c[(k == GROUPS - 1) ? k : k + 1]),
      .grp_o   (grp_c[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (keep) begin
      ring_q[wp_q] <= s_axis_tdata;
    end
    rd_data_q <= ring_q[rd_addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      rate_q   <= 16'd1;
      maxg_q   <= 5'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        strtt_pkg::RegEnable:     enable_q <= cfg_data_i[0];
        strtt_pkg::RegSampleRate: rate_q   <= cfg_data_i;
        strtt_pkg::RegMaxGroups:  maxg_q   <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      fill_q      <= '0;
      phase_q     <= '0;
      rd_addr_q   <= '0;
      rd_cnt_q    <= '0;
      rd_v_q      <= 1'b0;
      drain_q     <= '0;
      step_q      <= '0;
      hold_q      <= '0;
      hold_v_q    <= 1'b0;
      rem_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_empty_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      rd_v_q <= issue;
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && s_axis_tuser == strtt_pkg::OpLog && enable_q) begin
            phase_q <= (phase_nx >= {1'b0, rate_eff}) ? 16'd0 : phase_nx[15:0];
            if (keep) begin
              wp_q <= (wp_q == PW'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
              if (fill_q != FW'(RING_DEPTH)) begin
                fill_q <= fill_q + 1'b1;
              end
            end
          end else if (in_acc && s_axis_tuser == strtt_pkg::OpReport) begin
            if (!enable_q || fill_q == '0 || limit == '0) begin
              state_q <= S_EMPTY;
            end else begin
              state_q   <= S_WALK;
              rd_addr_q <= start;
              rd_cnt_q  <= '0;
            end
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= '0;
            out_empty_q <= 1'b1;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_WALK: begin
          if (issue) begin
            rd_cnt_q  <= rd_cnt_q + 1'b1;
            rd_addr_q <= (rd_addr_q == PW'(RING_DEPTH - 1)) ? '0 : rd_addr_q + 1'b1;
          end else begin
            state_q <= S_DRAIN;
            drain_q <= '0;
          end
        end
        S_DRAIN: begin
          drain_q <= drain_q + 1'b1;
          if (drain_q == DW'(GROUPS + 1)) begin
            state_q  <= S_SORT;
            step_q   <= '0;
            hold_v_q <= 1'b0;
            rem_q    <= 1'b0;
          end
        end
        S_SORT: begin
          if (grp_c[0].v) begin
            if (!hold_v_q) begin
              hold_q   <= grp_c[0];
              hold_v_q <= 1'b1;
            end else begin
              rem_q <= 1'b1;
              if (grp_c[0].tot > hold_q.tot) begin
                hold_q <= grp_c[0];
              end
            end
          end
          step_q <= step_q + 1'b1;
          if (step_q == LW'(GROUPS - 1)) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {7'd0, hold_q.cnt, hold_q.tot, hold_q.id};
            out_empty_q <= 1'b0;
            out_last_q  <= !rem_q;
            state_q     <= rem_q ? S_SORT : S_IDLE;
            step_q      <= '0;
            hold_v_q    <= 1'b0;
            rem_q       <= 1'b0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `STRTT_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= FW'(RING_DEPTH), "fill count above depth")
  `STRTT_ASSERT_NOW(a_walk_bound, state_q == S_WALK, rd_cnt_q <= fill_q, "ring walk past fill")
  `STRTT_ASSERT_NEXT(a_off_still, in_acc && !enable_q, $stable(fill_q) && $stable(phase_q),
                     "log state moved while disabled")
  `STRTT_ASSERT_NOW(a_empty_last, out_valid_q && out_empty_q, out_last_q,
                    "empty result without last")
  `STRTT_ASSERT_NOW(a_sort_quiet, state_q == S_SORT, !rd_v_q && !ent_c[GROUPS-1].v,
                    "cell chain not drained before sort")

endmodule

// ----- dv/tb_sampled_trace_ring_thread_topn_core.sv -----
`timescale 1ns / 100ps

module tb_sampled_trace_ring_thread_topn_core;

  localparam int unsigned IdW   = strtt_pkg::IdW;
  localparam int unsigned SizeW = strtt_pkg::SizeW;
  localparam int unsigned TotW  = strtt_pkg::TotW;
  localparam int unsigned CntW  = strtt_pkg::CntW;
  localparam int unsigned EntW  = strtt_pkg::EntW;
  localparam int unsigned DEPTH = 4096;
  localparam int unsigned NGRP  = 16;
  localparam logic [TotW-1:0] TOT_SAT = '1;
  localparam logic [CntW-1:0] CNT_SAT = '1;

  typedef struct packed {
    logic [IdW-1:0]  thread;
    logic [TotW-1:0] total;
    logic [CntW-1:0] count;
    logic            empty;
    logic            last;
  } group_rec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  sampled_trace_ring_thread_topn_core u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always #4 clk_i = ~clk_i;

  // shadow state
  logic            sh_enable;
  logic [15:0]     sh_rate;
  logic [4:0]      sh_max_groups;
  logic [EntW-1:0] sh_ring [DEPTH];
  int unsigned     sh_wptr, sh_fill, sh_phase;

  group_rec_t expected_groups[$];
  int unsigned errors = 0;

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      strtt_pkg::RegEnable:     sh_enable = val[0];
      strtt_pkg::RegSampleRate: sh_rate = val;
      strtt_pkg::RegMaxGroups:  sh_max_groups = val[4:0];
      default: ;
    endcase
  endtask

  function automatic void record_event(logic [IdW-1:0] tid, logic [SizeW-1:0] sz);
    int unsigned rate, nxt;
    logic keep;
    rate = (sh_rate == 0) ? 1 : sh_rate;
    keep = (sh_phase == 0);
    nxt = sh_phase + 1;
    sh_phase = (nxt >= rate) ? 0 : nxt;
    if (!keep) return;
    sh_ring[sh_wptr] = {tid, sz};
    sh_wptr = (sh_wptr + 1 >= DEPTH) ? 0 : sh_wptr + 1;
    if (sh_fill < DEPTH) sh_fill++;
  endfunction

  function automatic void predict_report();
    int unsigned lim, ng, start, j;
    logic [IdW-1:0]  ids [NGRP];
    logic [TotW:0]   tots [NGRP];
    logic [CntW-1:0] cnts [NGRP];
    logic [IdW-1:0]  tid;
    logic [TotW:0]   sum;
    group_rec_t r;
    lim = (sh_max_groups > NGRP) ? NGRP : sh_max_groups;
    ng = 0;
    if (!sh_enable || sh_fill == 0 || lim == 0) begin
      r = '0;
      r.empty = 1'b1;
      r.last = 1'b1;
      expected_groups.push_back(r);
      return;
    end
    start = (sh_wptr + DEPTH - sh_fill) % DEPTH;
    for (int unsigned i = 0; i < sh_fill; i++) begin
      tid = sh_ring[(start + i) % DEPTH][EntW-1:SizeW];
      for (j = 0; j < ng; j++) if (ids[j] == tid) break;
      if (j == ng) begin
        if (ng >= lim) continue;
        ids[j] = tid;
        tots[j] = '0;
        cnts[j] = '0;
        ng++;
      end
      sum = tots[j] + sh_ring[(start + i) % DEPTH][SizeW-1:0];
      tots[j] = (sum > TOT_SAT) ? {1'b0, TOT_SAT} : sum;
      if (cnts[j] != CNT_SAT) cnts[j]++;
    end
    for (int unsigned a = 0; a + 1 < ng; a++)
      for (int unsigned b = a + 1; b < ng; b++)
        if (tots[b] > tots[a]) begin
          {ids[a], ids[b]} = {ids[b], ids[a]};
          {tots[a], tots[b]} = {tots[b], tots[a]};
          {cnts[a], cnts[b]} = {cnts[b], cnts[a]};
        end
    for (int unsigned a = 0; a < ng; a++) begin
      r.thread = ids[a];
      r.total = tots[a][TotW-1:0];
      r.count = cnts[a];
      r.empty = 1'b0;
      r.last = (a + 1 == ng);
      expected_groups.push_back(r);
    end
  endfunction

  task automatic send_item(input logic op, input logic [IdW-1:0] tid,
                           input logic [SizeW-1:0] sz);
    int unsigned gap;
    gap = $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {sz, tid};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (op == strtt_pkg::OpReport) predict_report();
    else if (sh_enable) record_event(tid, sz);
  endtask

  task automatic drain();
    int unsigned guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (expected_groups.size() != 0 && guard < 400000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (100) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    group_rec_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_groups.size() == 0) begin
        $display("%0t unexpected transfer: tdata=%h tuser=%b tlast=%b", $time,
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
        errors++;
      end else begin
        e = expected_groups.pop_front();
        if (m_axis_tdata[IdW-1:0] !== e.thread) begin
          $display("%0t group_thread exp %h got %h", $time, e.thread, m_axis_tdata[IdW-1:0]);
          errors++;
        end
        if (m_axis_tdata[IdW+TotW-1:IdW] !== e.total) begin
          $display("%0t total_bytes exp %h got %h", $time, e.total,
                   m_axis_tdata[IdW+TotW-1:IdW]);
          errors++;
        end
        if (m_axis_tdata[IdW+TotW+CntW-1:IdW+TotW] !== e.count) begin
          $display("%0t event_count exp %h got %h", $time, e.count,
                   m_axis_tdata[IdW+TotW+CntW-1:IdW+TotW]);
          errors++;
        end
        if (m_axis_tuser !== e.empty) begin
          $display("%0t empty_res exp %b got %b", $time, e.empty, m_axis_tuser);
          errors++;
        end
        if (m_axis_tlast !== e.last) begin
          $display("%0t last exp %b got %b", $time, e.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int unsigned w;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
        if (w != 0) begin
          m_axis_tready <= 1'b0;
          repeat (w) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
      end else if (!m_axis_tready) begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [SizeW-1:0] rand_size();
    case ($urandom_range(0, 3))
      0: return '1;
      1: return '0;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_disabled();
    send_item(strtt_pkg::OpReport, 16'h0, 32'h0);
    send_item(strtt_pkg::OpLog, 16'h1234, 32'h10);
    send_item(strtt_pkg::OpReport, 16'h0, 32'h0);
    drain();
  endtask

  task automatic test_directed();
    write_reg(strtt_pkg::RegEnable, 16'd1);
    send_item(strtt_pkg::OpReport, 16'h0, 32'h0);
    send_item(strtt_pkg::OpLog, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(strtt_pkg::OpLog, 16'h0000, 32'h0);
    send_item(strtt_pkg::OpLog, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(strtt_pkg::OpLog, 16'hAAAA, 32'h5555_5555);
    send_item(strtt_pkg::OpLog, 16'h5555, 32'hAAAA_AAAA);
    send_item(strtt_pkg::OpReport, 16'hFFFF, 32'hFFFF_FFFF);
    drain();
    write_reg(strtt_pkg::RegMaxGroups, 16'd0);
    send_item(strtt_pkg::OpReport, 16'h0, 32'h0);
    drain();
    write_reg(strtt_pkg::RegMaxGroups, 16'd31);
    send_item(strtt_pkg::OpReport, 16'h0, 32'h0);
    drain();
    // table full: more threads than groups
    write_reg(strtt_pkg::RegMaxGroups, 16'd2);
    for (int i = 0; i < 5; i++) begin
      send_item(strtt_pkg::OpLog, 16'(i + 16'h100), 32'(i * 7 + 1));
    end
    send_item(strtt_pkg::OpReport, 16'h0, 32'h0);
    drain();
  endtask

  task automatic test_sampling();
    write_reg(strtt_pkg::RegMaxGroups, 16'd16);
    write_reg(strtt_pkg::RegSampleRate, 16'd5);
    for (int i = 0; i < 8; i++) begin
      send_item(strtt_pkg::OpLog, 16'($urandom_range(0, 3)), rand_size());
    end
    write_reg(strtt_pkg::RegSampleRate, 16'd2);   // drops below phase
    for (int i = 0; i < 3; i++) begin
      send_item(strtt_pkg::OpLog, 16'($urandom_range(0, 3)), rand_size());
    end
    write_reg(strtt_pkg::RegSampleRate, 16'd0);
    for (int i = 0; i < 3; i++) begin
      send_item(strtt_pkg::OpLog, 16'($urandom_range(0, 3)), rand_size());
    end
    write_reg(strtt_pkg::RegSampleRate, 16'hFFFF);
    for (int i = 0; i < 3; i++) begin
      send_item(strtt_pkg::OpLog, 16'($urandom_range(0, 3)), rand_size());
    end
    send_item(strtt_pkg::OpReport, 16'h0, 32'h0);
    drain();
  endtask

  task automatic test_random();
    int unsigned phase_items;
    logic [IdW-1:0] tid;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(strtt_pkg::RegEnable, (ph == 3) ? 16'd0 : 16'd1);
      write_reg(strtt_pkg::RegSampleRate, 16'($urandom_range(1, 3)));
      write_reg(strtt_pkg::RegMaxGroups, 16'($urandom_range(0, 20)));
      phase_items = 0;
      while (phase_items < 45) begin
        if ($urandom_range(0, 7) == 0) begin
          send_item(strtt_pkg::OpReport, 16'($urandom()), $urandom());
        end else begin
          tid = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 20));
          send_item(strtt_pkg::OpLog, tid, rand_size());
        end
        phase_items++;
        if (phase_items == 20 && ph == 1) drain();
      end
      send_item(strtt_pkg::OpReport, 16'h0, 32'h0);
      drain();
    end
  endtask

  initial begin
    sh_enable = 1'b0;
    sh_rate = 16'd1;
    sh_max_groups = 5'd16;
    sh_wptr = 0;
    sh_fill = 0;
    sh_phase = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_disabled();
    test_directed();
    test_sampling();
    test_random();
    drain();
    if (errors == 0 && expected_groups.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/strtt_pkg.sv
rtl/strtt_cell.sv
rtl/sampled_trace_ring_thread_topn_core.sv
dv/tb_sampled_trace_ring_thread_topn_core.sv
